@@ rtl/bh_pkg.sv @@
package bh_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 3;
	localparam int WC_W   = 6;   // holds a word count up to 63
	localparam int PR_W   = 4;   // permutation row 0..9

	localparam logic [PR_W-1:0]  LAST_PERM = 4'd9;
	localparam logic [IDX_W-1:0] LAST_IDX  = 3'd7;
	localparam logic [2:0]       LAST_G    = 3'd7;
	localparam logic [2:0]       DIAG_G    = 3'd3;  // last column step, diagonalize after it
	localparam logic [3:0]       PAD_ONE_POS = 4'd13;
	localparam logic [3:0]       PAD_LEN_POS = 4'd15;
	localparam logic [WORD_W-1:0] PAD_MARK   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] PAD_ONE    = 32'h0000_0001;

	typedef logic [3:0][WORD_W-1:0] row_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} quad_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_RUN,
		S_FOLD,
		S_DONE
	} fsm_t;

	typedef enum logic [1:0] {
		BLK_DATA,
		BLK_FIN1,
		BLK_FIN2
	} blk_mode_t;

	localparam logic [7:0][WORD_W-1:0] IV = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	localparam logic [15:0][WORD_W-1:0] PI = {
		32'hB5470917, 32'h3F84D5B5, 32'hC97C50DD, 32'hC0AC29B7,
		32'h34E90C6C, 32'hBE5466CF, 32'h38D01377, 32'h452821E6,
		32'hEC4E6C89, 32'h082EFA98, 32'h299F31D0, 32'hA4093822,
		32'h03707344, 32'h13198A2E, 32'h85A308D3, 32'h243F6A88
	};

	// message word index for a permutation row and position, first position in the top nibble
	function automatic logic [3:0] sigma(input logic [PR_W-1:0] row, input logic [3:0] pos);
		logic [63:0] str;
		logic [63:0] shifted;
		logic [5:0]  sh;
		case (row)
			4'd0:    str = 64'h0123456789ABCDEF;
			4'd1:    str = 64'hEA489FD61C02B753;
			4'd2:    str = 64'hB8C052FDAE367194;
			4'd3:    str = 64'h7931DCBE265A40F8;
			4'd4:    str = 64'h905724AFE1BC683D;
			4'd5:    str = 64'h2C6A0B834D75FE19;
			4'd6:    str = 64'hC51FED4A0763928B;
			4'd7:    str = 64'hDB7EC13950F4862A;
			4'd8:    str = 64'h6FE9B308C2D714A5;
			4'd9:    str = 64'hA2847615FB9E3CD0;
			default: str = 64'h0123456789ABCDEF;
		endcase
		sh = {~pos, 2'b00};
		shifted = str >> sh;
		return shifted[3:0];
	endfunction

	// rotate a row left by s columns: element j takes element j+s
	function automatic row_t rot_row(input row_t r, input logic [1:0] s);
		row_t o;
		for (int j = 0; j < 4; j++) begin
			o[j] = r[2'(j) + s];
		end
		return o;
	endfunction

endpackage

@@ rtl/bh_msg_if.sv @@
interface bh_msg_if;
	logic                        valid;
	logic                        ready;
	logic [bh_pkg::WORD_W-1:0]   message_word;

	modport source (output valid, output message_word, input ready);
	modport sink   (input valid, input message_word, output ready);
endinterface

@@ rtl/bh_dig_if.sv @@
interface bh_dig_if;
	logic                        valid;
	logic                        ready;
	logic [bh_pkg::WORD_W-1:0]   digest_word;
	logic [bh_pkg::IDX_W-1:0]    word_index;
	logic                        last;

	modport source (output valid, output digest_word, output word_index, output last,
		input ready);
	modport sink   (input valid, input digest_word, input word_index, input last,
		output ready);
endinterface

@@ rtl/bh_gmix.sv @@
// Half of the G function: one message/constant add, two rotates.
// half = 0 uses rotations 16/12, half = 1 uses 8/7.
module bh_gmix (
	input  bh_pkg::quad_t              q_in,
	input  logic [bh_pkg::WORD_W-1:0]  mk,
	input  logic                       half,
	output bh_pkg::quad_t              q_out
);

	logic [bh_pkg::WORD_W-1:0] a1, c1, dx, bx, d1, b1;

	always_comb begin
		a1 = q_in.a + q_in.b + mk;
		dx = q_in.d ^ a1;
		d1 = half ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
		c1 = q_in.c + d1;
		bx = q_in.b ^ c1;
		b1 = half ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
		q_out.a = a1;
		q_out.b = b1;
		q_out.c = c1;
		q_out.d = d1;
	end

endmodule

@@ rtl/blake256_fixed_200_byte_hash.sv @@
// BLAKE-256 of one fixed-length message, salt zero. Operation:
//   a word that does not close a block is taken without a stall;
//   each compression runs LOAD, RUN and FOLD on one half-G unit, with msg.ready low;
//   the closing word adds a data block if it ends one, 1 or 2 final blocks and a digest copy
//   held until the prior digest drains; digest words go out 1 per cycle while ready is high.
// Reset: async active low; chain returns to the IV, word count and FSM clear.
module blake256_fixed_200_byte_hash #(
	parameter int ROUNDS        = 14,
	parameter int MESSAGE_WORDS = 50
) (
	input  logic     clk,
	input  logic     arst_n,
	bh_msg_if.sink   msg,
	bh_dig_if.source digest
);

	localparam int RW  = $clog2(ROUNDS);
	localparam int REM = MESSAGE_WORDS % 16;

	localparam logic [RW-1:0]                 LAST_ROUND = RW'(ROUNDS - 1);
	localparam logic [bh_pkg::WC_W-1:0]       MW_C       = bh_pkg::WC_W'(MESSAGE_WORDS);
	localparam logic [3:0]                    REM_C      = 4'(REM);
	localparam logic [bh_pkg::WORD_W-1:0]     BITS       = 32'(MESSAGE_WORDS * 32);
	// padding and length fit behind the data in the first final block
	localparam logic                          TAIL_FIN1  = (REM <= 13);
	// fourteen or fifteen words left: a second block with no data, only the closing pad bit and the length, follows
	localparam logic                          TWO_FINAL  = (REM > 13);
	// counter mixed into the first final block unless it holds no data
	localparam logic                          MIX_FIN1   = (REM != 0);

	// ---------------------------------------------------------------
	// Sequencer state
	// ---------------------------------------------------------------
	bh_pkg::fsm_t      state_q, state_d;
	bh_pkg::blk_mode_t mode_q, mode_d;
	logic              mode_we;

	logic [bh_pkg::WC_W-1:0] wc_q, wc_inc;
	logic [RW-1:0]           round_q, round_n;
	logic [bh_pkg::PR_W-1:0] pr_q, pr_n;   // permutation row = round mod 10
	logic [2:0]              g_q, g_n;     // which G of the round
	logic                    half_q, half_n;
	logic                    last_step;

	logic take, load_en, run_en, fold_en, copy_en, fetch_en;

	// ---------------------------------------------------------------
	// Datapath storage
	// ---------------------------------------------------------------
	bh_pkg::row_t                      v_q [4];     // working state, one row per entry
	bh_pkg::row_t                      v_d [4];
	logic [7:0][bh_pkg::WORD_W-1:0]    chain_q;
	logic [bh_pkg::WORD_W-1:0]         block_mem [16];
	logic [bh_pkg::WORD_W-1:0]         m_q;         // message word for the current half step
	logic [bh_pkg::WORD_W-1:0]         k_q;         // matching pi constant
	logic [bh_pkg::WORD_W-1:0]         digest_q [8];
	logic                              out_busy_q;
	logic [bh_pkg::IDX_W-1:0]          out_idx_q;

	assign wc_inc = wc_q + 1'b1;
	assign msg.ready = (state_q == bh_pkg::S_IDLE);
	assign take = msg.valid && msg.ready;

	// next position in the round schedule
	always_comb begin
		half_n  = ~half_q;
		g_n     = g_q;
		round_n = round_q;
		pr_n    = pr_q;
		if (half_q) begin
			g_n = g_q + 3'd1;
			if (g_q == bh_pkg::LAST_G) begin
				round_n = round_q + 1'b1;
				pr_n    = (pr_q == bh_pkg::LAST_PERM) ? '0 : pr_q + 1'b1;
			end
		end
	end

	assign last_step = (state_q == bh_pkg::S_RUN) && (round_q == LAST_ROUND) &&
		(g_q == bh_pkg::LAST_G) && half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		mode_we = 1'b0;
		load_en = 1'b0;
		run_en  = 1'b0;
		fold_en = 1'b0;
		copy_en = 1'b0;
		case (state_q)
			bh_pkg::S_IDLE: begin
				if (take) begin
					if (wc_inc[3:0] == 4'd0) begin
						mode_d  = bh_pkg::BLK_DATA;
						mode_we = 1'b1;
						state_d = bh_pkg::S_LOAD;
					end else if (wc_inc == MW_C) begin
						mode_d  = bh_pkg::BLK_FIN1;
						mode_we = 1'b1;
						state_d = bh_pkg::S_LOAD;
					end
				end
			end
			bh_pkg::S_LOAD: begin
				load_en = 1'b1;
				state_d = bh_pkg::S_RUN;
			end
			bh_pkg::S_RUN: begin
				run_en = 1'b1;
				if (last_step) begin
					state_d = bh_pkg::S_FOLD;
				end
			end
			bh_pkg::S_FOLD: begin
				fold_en = 1'b1;
				case (mode_q)
					bh_pkg::BLK_DATA: begin
						if (wc_q == MW_C) begin
							mode_d  = bh_pkg::BLK_FIN1;
							mode_we = 1'b1;
							state_d = bh_pkg::S_LOAD;
						end else begin
							state_d = bh_pkg::S_IDLE;
						end
					end
					bh_pkg::BLK_FIN1: begin
						if (TWO_FINAL) begin
							mode_d  = bh_pkg::BLK_FIN2;
							mode_we = 1'b1;
							state_d = bh_pkg::S_LOAD;
						end else begin
							state_d = bh_pkg::S_DONE;
						end
					end
					default: state_d = bh_pkg::S_DONE;
				endcase
			end
			bh_pkg::S_DONE: begin
				// wait until the previous digest has drained
				if (!out_busy_q) begin
					copy_en = 1'b1;
					state_d = bh_pkg::S_IDLE;
				end
			end
			default: state_d = bh_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bh_pkg::BLK_DATA;
			wc_q    <= '0;
			round_q <= '0;
			pr_q    <= '0;
			g_q     <= '0;
			half_q  <= 1'b0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_d;
			end
			if (take) begin
				wc_q <= wc_inc;
			end else if (copy_en) begin
				wc_q <= '0;
			end
			if (run_en) begin
				round_q <= round_n;
				pr_q    <= pr_n;
				g_q     <= g_n;
				half_q  <= half_n;
			end else if (fold_en) begin
				round_q <= '0;
				pr_q    <= '0;
				g_q     <= '0;
				half_q  <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Block buffer and operand fetch
	// Word for step n is registered in the cycle before its use: LOAD fetches step 0,
	// each RUN cycle fetches the step that follows it.
	// ---------------------------------------------------------------
	logic [bh_pkg::PR_W-1:0]   f_row;
	logic [2:0]                f_g;
	logic                      f_half;
	logic [3:0]                f_jm, f_jk;
	logic                      f_use_buf, tail;
	logic [bh_pkg::WORD_W-1:0] pad_word;

	assign fetch_en = load_en || run_en;

	always_comb begin
		f_row  = load_en ? pr_q   : pr_n;
		f_g    = load_en ? g_q    : g_n;
		f_half = load_en ? half_q : half_n;
		f_jm   = bh_pkg::sigma(f_row, {f_g, f_half});
		f_jk   = bh_pkg::sigma(f_row, {f_g, ~f_half});

		// final blocks build their padding on the fly instead of writing the buffer
		f_use_buf = (mode_q == bh_pkg::BLK_DATA) ||
			((mode_q == bh_pkg::BLK_FIN1) && (f_jm < REM_C));
		tail = (mode_q == bh_pkg::BLK_FIN2) || ((mode_q == bh_pkg::BLK_FIN1) && TAIL_FIN1);
		pad_word = '0;
		if ((mode_q == bh_pkg::BLK_FIN1) && (f_jm == REM_C)) begin
			pad_word = pad_word | bh_pkg::PAD_MARK;
		end
		if (tail && (f_jm == bh_pkg::PAD_ONE_POS)) begin
			pad_word = pad_word | bh_pkg::PAD_ONE;
		end
		if (tail && (f_jm == bh_pkg::PAD_LEN_POS)) begin
			pad_word = pad_word | BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			block_mem[wc_q[3:0]] <= msg.message_word;
		end
		if (fetch_en) begin
			m_q <= f_use_buf ? block_mem[f_jm] : pad_word;
			k_q <= bh_pkg::PI[f_jk];
		end
	end

	// ---------------------------------------------------------------
	// Shared half-G unit on column 0; rows rotate after each full G so
	// the next column (or diagonal) lines up at column 0.
	// ---------------------------------------------------------------
	bh_pkg::quad_t g_in, g_out;

	assign g_in = '{a: v_q[0][0], b: v_q[1][0], c: v_q[2][0], d: v_q[3][0]};

	bh_gmix u_gmix (
		.q_in  (g_in),
		.mk    (m_q ^ k_q),
		.half  (half_q),
		.q_out (g_out)
	);

	logic [bh_pkg::WORD_W-1:0] ctr;
	logic                      mix_ctr;

	always_comb begin
		bh_pkg::row_t w;
		logic [1:0]   s;
		ctr     = (mode_q == bh_pkg::BLK_DATA) ? 32'({wc_q, 5'b0}) : BITS;
		mix_ctr = (mode_q == bh_pkg::BLK_DATA) || ((mode_q == bh_pkg::BLK_FIN1) && MIX_FIN1);
		for (int r = 0; r < 4; r++) begin
			w = v_q[r];
			case (r)
				0:       w[0] = g_out.a;
				1:       w[0] = g_out.b;
				2:       w[0] = g_out.c;
				default: w[0] = g_out.d;
			endcase
			// diagonalize after G3, undo after G7
			if (g_q == bh_pkg::DIAG_G) begin
				s = 2'd1 + 2'(r);
			end else if (g_q == bh_pkg::LAST_G) begin
				s = 2'd1 - 2'(r);
			end else begin
				s = 2'd1;
			end
			v_d[r] = half_q ? bh_pkg::rot_row(w, s) : w;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			v_q[0] <= chain_q[3:0];
			v_q[1] <= chain_q[7:4];
			v_q[2] <= bh_pkg::PI[3:0];
			v_q[3] <= mix_ctr ? (bh_pkg::PI[7:4] ^ {64'd0, ctr, ctr}) : bh_pkg::PI[7:4];
		end else if (run_en) begin
			for (int r = 0; r < 4; r++) begin
				v_q[r] <= v_d[r];
			end
		end
	end

	// chain: fold at the end of each block, back to IV once the digest is copied to the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= bh_pkg::IV;
		end else if (fold_en) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i]     <= chain_q[i]     ^ v_q[0][i] ^ v_q[2][i];
				chain_q[i + 4] <= chain_q[i + 4] ^ v_q[1][i] ^ v_q[3][i];
			end
		end else if (copy_en) begin
			chain_q <= bh_pkg::IV;
		end
	end

	// ---------------------------------------------------------------
	// Digest output buffer: frees the core for the next message
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (copy_en) begin
			for (int i = 0; i < 8; i++) begin
				digest_q[i] <= chain_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else if (copy_en) begin
			out_busy_q <= 1'b1;
			out_idx_q  <= '0;
		end else if (out_busy_q && digest.ready) begin
			if (out_idx_q == bh_pkg::LAST_IDX) begin
				out_busy_q <= 1'b0;
			end
			out_idx_q <= out_idx_q + 1'b1;
		end
	end

	assign digest.valid       = out_busy_q;
	assign digest.digest_word = digest_q[out_idx_q];
	assign digest.word_index  = out_idx_q;
	assign digest.last        = (out_idx_q == bh_pkg::LAST_IDX);

`ifndef SYNTHESIS
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= MW_C)
		else $error("word count past message length");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bh_pkg::S_RUN |-> round_q <= LAST_ROUND)
		else $error("round counter overran");

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bh_pkg::S_LOAD |-> (round_q == '0 && g_q == '0 && !half_q && pr_q == '0))
		else $error("schedule not cleared at block start");

	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		copy_en |=> (out_busy_q && out_idx_q == '0 && wc_q == '0))
		else $error("digest copy did not arm output");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bh_pkg::S_RUN || state_q == bh_pkg::S_LOAD) |-> !take)
		else $error("word taken during compression");
`endif

endmodule
